[rtl/core/pdm_pkg.sv]
`default_nettype none

package pdm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int CHARGE_W   = 32;
	localparam int MODE_W     = 2;
	localparam int SHIFT_W    = 5;
	localparam int BPS_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE,
		CFG_SHIFT,
		CFG_BPS
	} cfg_idx_t;

	// modulator modes; the fourth code runs as the RC midpoint mode
	localparam logic [MODE_W-1:0] MODE_ACC       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RC_MID    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RC_SIMPLE = 2'd2;

	localparam logic [MODE_W-1:0]   MODE_RESET  = MODE_ACC;
	localparam logic [SHIFT_W-1:0]  SHIFT_RESET = 5'd4;
	localparam logic [BPS_W-1:0]    BPS_RESET   = 8'd32;
	localparam logic [CHARGE_W-1:0] CHARGE_MID  = 32'h8000_0000;

	// controller to datapath commands
	typedef struct packed {
		logic load;  // latch a new sample
		logic step;  // produce one PDM bit
		logic emit;  // move the finished word to the output register
	} pdm_cmd_t;

endpackage

`default_nettype wire

[rtl/core/pdm_pcm_if.sv]
`default_nettype none

interface pdm_pcm_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pdm_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[rtl/core/pdm_word_if.sv]
`default_nettype none

interface pdm_word_if #(
	parameter int WORD_BITS = 32
);
	localparam int CNT_W = $clog2(WORD_BITS + 1);

	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] pdm_word;
	logic [CNT_W-1:0]     bit_count;
	logic                 last;

	modport source (output valid, output pdm_word, output bit_count, output last, input ready);
	modport sink   (input valid, input pdm_word, input bit_count, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/pdm_datapath.sv]
`default_nettype none

module pdm_datapath #(
	parameter int WORD_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire pdm_pkg::pdm_cmd_t                    cmd,
	input  wire logic [pdm_pkg::MODE_W-1:0]           mode,
	input  wire logic [pdm_pkg::SHIFT_W-1:0]          filter_shift,
	input  wire logic                                 reload,
	input  wire logic [pdm_pkg::MODE_W-1:0]           reload_mode,
	input  wire logic signed [pdm_pkg::SAMPLE_W-1:0]  sample,
	output logic [WORD_BITS-1:0]                      pdm_word
);

	logic [pdm_pkg::CHARGE_W-1:0] charge_q;
	logic [pdm_pkg::SAMPLE_W-1:0] offset_q;
	logic [WORD_BITS-1:0]         shift_q;
	logic [WORD_BITS-1:0]         word_q;

	logic [pdm_pkg::SAMPLE_W:0]   acc_sum;
	logic [pdm_pkg::CHARGE_W-1:0] fall;
	logic [pdm_pkg::CHARGE_W-1:0] rise;
	logic [pdm_pkg::CHARGE_W-1:0] down;
	logic [pdm_pkg::CHARGE_W-1:0] up;
	logic [pdm_pkg::CHARGE_W:0]   span;
	logic [pdm_pkg::CHARGE_W-1:0] mid;
	logic [pdm_pkg::CHARGE_W-1:0] target;
	logic [pdm_pkg::CHARGE_W-1:0] charge_next;
	logic                         pdm_bit;

	always_comb begin
		// accumulator: charge stays below 2^16, so the carry is bit 16
		acc_sum = {1'b0, charge_q[pdm_pkg::SAMPLE_W-1:0]} + {1'b0, offset_q};
		fall    = charge_q >> filter_shift;
		rise    = (~charge_q) >> filter_shift;
		down    = charge_q - fall;
		up      = charge_q + rise;
		span    = {1'b0, fall} + {1'b0, rise};
		mid     = down + span[pdm_pkg::CHARGE_W:1];
		target  = {offset_q, {pdm_pkg::SAMPLE_W{1'b0}}};
		case (mode)
			pdm_pkg::MODE_ACC: begin
				pdm_bit     = acc_sum[pdm_pkg::SAMPLE_W];
				charge_next = {{(pdm_pkg::CHARGE_W - pdm_pkg::SAMPLE_W){1'b0}},
					acc_sum[pdm_pkg::SAMPLE_W-1:0]};
			end
			pdm_pkg::MODE_RC_SIMPLE: begin
				pdm_bit     = target > charge_q;
				charge_next = pdm_bit ? up : down;
			end
			default: begin
				pdm_bit     = target > mid;
				charge_next = pdm_bit ? up : down;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q <= '0;
		end else if (reload) begin
			charge_q <= (reload_mode == pdm_pkg::MODE_ACC) ? '0 : pdm_pkg::CHARGE_MID;
		end else if (cmd.step) begin
			charge_q <= charge_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			offset_q <= {~sample[pdm_pkg::SAMPLE_W-1], sample[pdm_pkg::SAMPLE_W-2:0]};
			shift_q  <= '0;
		end else if (cmd.emit) begin
			word_q  <= {shift_q[WORD_BITS-2:0], pdm_bit};
			shift_q <= '0;
		end else if (cmd.step) begin
			shift_q <= {shift_q[WORD_BITS-2:0], pdm_bit};
		end
	end

	assign pdm_word = word_q;

endmodule

`default_nettype wire

[rtl/core/pdm_ctrl.sv]
`default_nettype none

module pdm_ctrl #(
	parameter int WORD_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic [pdm_pkg::BPS_W-1:0]         total,
	input  wire logic                              out_ready,
	output logic                                   in_ready,
	output pdm_pkg::pdm_cmd_t                      cmd,
	output logic                                   out_valid,
	output logic [$clog2(WORD_BITS + 1)-1:0]       bit_count,
	output logic                                   last
);

	localparam int WB_W  = $clog2(WORD_BITS);
	localparam int CNT_W = $clog2(WORD_BITS + 1);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t                      state_q;
	logic [pdm_pkg::BPS_W-1:0]   left_q;
	logic [WB_W-1:0]             wbit_q;
	logic                        out_valid_q;
	logic [CNT_W-1:0]            count_q;
	logic                        last_q;
	logic                        word_end;
	logic                        final_bit;

	always_comb begin
		final_bit = (left_q == pdm_pkg::BPS_W'(1));
		word_end  = (wbit_q == WB_W'(WORD_BITS - 1)) || final_bit;
		in_ready  = (state_q == S_IDLE);
		cmd.load  = in_ready && in_valid;
		// hold the bit loop only when a finished word has no place to go
		cmd.step  = (state_q == S_RUN) && (!word_end || !out_valid_q || out_ready);
		cmd.emit  = cmd.step && word_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			left_q      <= '0;
			wbit_q      <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				count_q     <= CNT_W'(wbit_q) + CNT_W'(1);
				last_q      <= final_bit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.load && (total != '0)) begin
						state_q <= S_RUN;
						left_q  <= total;
						wbit_q  <= '0;
					end
				end
				S_RUN: begin
					if (cmd.step) begin
						left_q <= left_q - pdm_pkg::BPS_W'(1);
						wbit_q <= word_end ? '0 : wbit_q + WB_W'(1);
						if (final_bit) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign bit_count = count_q;
	assign last      = last_q;

endmodule

`default_nettype wire

[rtl/core/pcm_to_pdm_modulator.sv]
`default_nettype none

// Channel  Dir  Word contents                          Notes
// pcm      in   sample (signed 16 bit PCM)             one word per sample
// pdm      out  pdm_word, bit_count, last              up to WORD_BITS bits, latest bit LSB
// cfg      in   cfg_we, cfg_index, cfg_data            write only, index 0 mode, 1 shift, 2 bps
//
// After a sample is accepted, its N = min(bits per sample, MAX_BITS_PER_SAMPLE) PDM bits
// come one per cycle, unless the output stalls, through the single charge update
// loop in the datapath; no new sample is taken until its last bit is done.
// A sample with N = 0 gives no word and leaves the charge as it is.
// Reset clears the configuration to mode 0, shift 4, 32 bits and the charge to 0.
// A finished word waits in the output register; the bit loop stalls only when
// the next word is done while that register is still full.

module pcm_to_pdm_modulator #(
	parameter int MAX_BITS_PER_SAMPLE = 128,
	parameter int WORD_BITS           = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	pdm_pcm_if.sink                                pcm,
	pdm_word_if.source                             pdm,
	input  wire logic                              cfg_we,
	input  wire logic [pdm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pdm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// the bit count register cannot exceed its own width, so clip the cap to it
	localparam int BPS_MAX_I = (1 << pdm_pkg::BPS_W) - 1;
	localparam int CLIP_I    = (MAX_BITS_PER_SAMPLE > BPS_MAX_I) ? BPS_MAX_I
		: MAX_BITS_PER_SAMPLE;
	localparam logic [pdm_pkg::BPS_W-1:0] MAX_CLIP = pdm_pkg::BPS_W'(CLIP_I);

	logic [pdm_pkg::MODE_W-1:0]  mode_q;
	logic [pdm_pkg::SHIFT_W-1:0] filter_shift_q;
	logic [pdm_pkg::BPS_W-1:0]   bps_q;
	logic [pdm_pkg::BPS_W-1:0]   total;
	logic                        reload;
	pdm_pkg::pdm_cmd_t           cmd;

	// configuration registers; a mode write also reloads the charge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= pdm_pkg::MODE_RESET;
			filter_shift_q <= pdm_pkg::SHIFT_RESET;
			bps_q          <= pdm_pkg::BPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pdm_pkg::CFG_MODE:  mode_q         <= cfg_data[pdm_pkg::MODE_W-1:0];
				pdm_pkg::CFG_SHIFT: filter_shift_q <= cfg_data[pdm_pkg::SHIFT_W-1:0];
				pdm_pkg::CFG_BPS:   bps_q          <= cfg_data[pdm_pkg::BPS_W-1:0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	assign reload = cfg_we && (cfg_index == pdm_pkg::CFG_MODE);
	// saturate the bit count per sample at the configured cap
	assign total  = (bps_q > MAX_CLIP) ? MAX_CLIP : bps_q;

	pdm_ctrl #(
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pcm.valid),
		.total     (total),
		.out_ready (pdm.ready),
		.in_ready  (pcm.ready),
		.cmd       (cmd),
		.out_valid (pdm.valid),
		.bit_count (pdm.bit_count),
		.last      (pdm.last)
	);

	pdm_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (mode_q),
		.filter_shift (filter_shift_q),
		.reload       (reload),
		.reload_mode  (cfg_data[pdm_pkg::MODE_W-1:0]),
		.sample       (pcm.sample),
		.pdm_word     (pdm.pdm_word)
	);

`ifndef SYNTHESIS
	// a sample with bits to send takes the block out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(pcm.valid && pcm.ready && (total != '0)) |=> !pcm.ready)
		else $error("input still ready after accepting a sample with bits to send");

	// only the final word of a sample may be short
	a_full_inner_word: assert property (@(posedge clk) disable iff (!arst_n)
		(pdm.valid && !pdm.last) |-> (pdm.bit_count == WORD_BITS))
		else $error("non-final word is not full");

	// idle is reached only as the final word is loaded
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pcm.ready) |-> (pdm.valid && pdm.last))
		else $error("returned to idle without a final word");
`endif

endmodule

`default_nettype wire
